// ===== hw/rtl/paging_frame_allocator_core_defines.svh =====
// Assertion macros used by the checker file of the frame allocator.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef PAGING_FRAME_ALLOCATOR_CORE_DEFINES_SVH
`define PAGING_FRAME_ALLOCATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pfa_pkg.sv =====
`default_nettype none

package pfa_pkg;

  localparam int unsigned FRAME_W = 6;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned SIZE_W  = 17;
  localparam int unsigned PID_W   = 8;

  localparam logic [SIZE_W-1:0] MAX_FRAME_SIZE = 17'd65536;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_DEALLOC = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  // Register index, taken from paddr bit 2.
  localparam logic REG_TOTAL_FRAMES = 1'b0;
  localparam logic REG_FRAME_SIZE   = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic rd_issue;
    logic frame_move;
    logic scan_step;
    logic single_load;
  } pfa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_dealloc;
    logic req_refuse;
    logic req_zero;
    logic alloc_more;
    logic frame_pend;
    logic scan_busy;
    logic out_free;
  } pfa_stat_t;

  // Decoded configuration write.
  typedef struct packed {
    logic        wr_frames;
    logic        wr_size;
    logic [31:0] wdata;
  } pfa_cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pfa_ctrl.sv =====
`default_nettype none

module pfa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pfa_pkg::pfa_stat_t stat_i,
  output pfa_pkg::pfa_cmd_t  ctl_o
);
  import pfa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_SCAN,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   move;

  assign in_stall_o = (state_q != S_IDLE);
  assign move       = stat_i.frame_pend && stat_i.out_free;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.accept = 1'b1;
          if (stat_i.req_dealloc) begin
            state_d = S_SCAN;
          end else if (stat_i.req_refuse || stat_i.req_zero) begin
            state_d = S_DONE;
          end else begin
            state_d = S_ALLOC;
          end
        end
      end
      S_ALLOC: begin
        // One frame read in flight at most; a new read starts as the
        // previous one drains into the output register.
        ctl_o.frame_move = move;
        ctl_o.rd_issue   = stat_i.alloc_more && (!stat_i.frame_pend || move);
        if (!stat_i.alloc_more && move) begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        ctl_o.scan_step = 1'b1;
        if (!stat_i.scan_busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          ctl_o.single_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pfa_datapath.sv =====
`default_nettype none

module pfa_datapath #(
  parameter int unsigned FRAMES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pfa_pkg::pfa_cmd_t            ctl_i,
  output pfa_pkg::pfa_stat_t           stat_o,
  input  pfa_pkg::pfa_cfg_t            cfg_i,
  output logic [pfa_pkg::COUNT_W-1:0]  total_frames_o,
  output logic [pfa_pkg::SIZE_W-1:0]   frame_size_o,
  input  logic                         cmd_i,
  input  logic [pfa_pkg::PID_W-1:0]    pid_i,
  input  logic [pfa_pkg::COUNT_W-1:0]  num_pages_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         status_o,
  output logic                         frame_valid_o,
  output logic [pfa_pkg::FRAME_W-1:0]  frame_o,
  output logic                         last_o,
  output logic [pfa_pkg::COUNT_W-1:0]  frames_freed_o,
  output logic [pfa_pkg::COUNT_W-1:0]  free_frames_o,
  output logic [22:0]                  free_bytes_o,
  output logic [7:0]                   process_count_o,
  output logic [31:0]                  paged_in_o,
  output logic [31:0]                  paged_out_o
);
  import pfa_pkg::*;

  localparam int unsigned AW = $clog2(FRAMES);
  localparam logic [COUNT_W-1:0] FramesCnt = COUNT_W'(FRAMES);
  localparam logic [AW-1:0]      LastIdx   = AW'(FRAMES - 1);

  // Configuration and allocator state.
  logic [COUNT_W-1:0] tot_q, top_q, rp_q, freed_q;
  logic [SIZE_W-1:0]  fsz_q;
  logic [7:0]         proc_q;
  logic [31:0]        in_q, outc_q;
  logic [PID_W-1:0]   pid_q;
  logic               refuse_q;

  // Free stack: memory plus one valid bit per entry. An entry that is not
  // valid reads as its own index.
  logic [FRAME_W-1:0] stk_mem [FRAMES];
  logic [FRAMES-1:0]  stk_vld_q;
  logic [FRAME_W-1:0] stk_rd_q;
  logic               stk_rd_vld_q;
  logic [AW-1:0]      stk_rd_addr_q;
  logic               pend_q;

  // Owner table: valid bits in flops, owner ids in a memory.
  logic [PID_W-1:0]   own_mem [FRAMES];
  logic [FRAMES-1:0]  own_vld_q;
  logic [PID_W-1:0]   own_rd_q;

  // Scan sequencer.
  logic [AW-1:0]      sc_q, cmp_idx_q;
  logic               iss_done_q, cmp_vld_q, cmp_own_vld_q;

  // Output register.
  logic               out_vld_q;
  logic               status_q, fv_q, last_q;
  logic [FRAME_W-1:0] frame_q;
  logic [COUNT_W-1:0] ofreed_q, ofree_q;
  logic [22:0]        obytes_q;
  logic [7:0]         oproc_q;
  logic [31:0]        oin_q, oout_q;

  logic [COUNT_W-1:0] rp_dec, tf_raw, tf_new;
  logic [AW-1:0]      rd_addr, top_idx, own_idx;
  logic [FRAME_W-1:0] pend_frame;
  logic [SIZE_W-1:0]  fs_raw, fs_new;
  logic [23:0]        prod;
  logic               hit, push_ok, out_free, load;

  assign rp_dec     = rp_q - COUNT_W'(1);
  assign rd_addr    = rp_dec[AW-1:0];
  assign top_idx    = top_q[AW-1:0];
  assign pend_frame = stk_rd_vld_q ? stk_rd_q : FRAME_W'(stk_rd_addr_q);
  assign own_idx    = pend_frame[AW-1:0];
  assign hit        = cmp_vld_q && cmp_own_vld_q && (own_rd_q == pid_q);
  assign push_ok    = hit && (top_q < FramesCnt);
  assign prod       = 24'(top_q) * 24'(fsz_q);
  assign out_free   = !out_vld_q || !out_stall_i;
  assign load       = ctl_i.frame_move || ctl_i.single_load;

  assign tf_raw = cfg_i.wdata[COUNT_W-1:0];
  assign tf_new = (tf_raw == '0) ? COUNT_W'(1) : ((tf_raw > FramesCnt) ? FramesCnt : tf_raw);
  assign fs_raw = cfg_i.wdata[SIZE_W-1:0];
  assign fs_new = (fs_raw == '0) ? SIZE_W'(1) :
                  ((fs_raw > MAX_FRAME_SIZE) ? MAX_FRAME_SIZE : fs_raw);

  always_comb begin
    stat_o             = '0;
    stat_o.req_dealloc = (cmd_i == CMD_DEALLOC);
    stat_o.req_refuse  = (num_pages_i > top_q);
    stat_o.req_zero    = (num_pages_i == '0);
    stat_o.alloc_more  = (rp_q != top_q);
    stat_o.frame_pend  = pend_q;
    stat_o.scan_busy   = !iss_done_q || cmp_vld_q;
    stat_o.out_free    = out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q         <= FramesCnt;
      top_q         <= FramesCnt;
      rp_q          <= FramesCnt;
      fsz_q         <= 17'd4096;
      proc_q        <= '0;
      in_q          <= '0;
      outc_q        <= '0;
      freed_q       <= '0;
      refuse_q      <= 1'b0;
      stk_vld_q     <= '0;
      own_vld_q     <= '0;
      stk_rd_vld_q  <= 1'b0;
      stk_rd_addr_q <= '0;
      pend_q        <= 1'b0;
      sc_q          <= '0;
      cmp_idx_q     <= '0;
      cmp_own_vld_q <= 1'b0;
      iss_done_q    <= 1'b1;
      cmp_vld_q     <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      cmp_vld_q <= 1'b0;

      if (ctl_i.accept) begin
        freed_q    <= '0;
        rp_q       <= top_q;
        sc_q       <= '0;
        iss_done_q <= (cmd_i != CMD_DEALLOC);
        refuse_q   <= (cmd_i == CMD_ALLOC) && (num_pages_i > top_q);
        if (cmd_i == CMD_DEALLOC) begin
          if (proc_q != '0) begin
            proc_q <= proc_q - 8'd1;
          end
        end else if (num_pages_i <= top_q) begin
          // All counters take their final values now; the frames follow.
          top_q <= top_q - num_pages_i;
          in_q  <= in_q + 32'(num_pages_i);
          if (proc_q != 8'hFF) begin
            proc_q <= proc_q + 8'd1;
          end
        end
      end

      if (ctl_i.rd_issue) begin
        rp_q          <= rp_dec;
        stk_rd_vld_q  <= stk_vld_q[rd_addr];
        stk_rd_addr_q <= rd_addr;
        pend_q        <= 1'b1;
      end else if (ctl_i.frame_move) begin
        pend_q <= 1'b0;
      end

      if (ctl_i.frame_move) begin
        own_vld_q[own_idx] <= 1'b1;
      end

      if (ctl_i.scan_step && !iss_done_q) begin
        cmp_vld_q     <= 1'b1;
        cmp_idx_q     <= sc_q;
        cmp_own_vld_q <= own_vld_q[sc_q];
        sc_q          <= sc_q + AW'(1);
        if (sc_q == LastIdx) begin
          iss_done_q <= 1'b1;
        end
      end

      if (hit) begin
        own_vld_q[cmp_idx_q] <= 1'b0;
        freed_q              <= freed_q + COUNT_W'(1);
        outc_q               <= outc_q + 32'd1;
        if (push_ok) begin
          stk_vld_q[top_idx] <= 1'b1;
          top_q              <= top_q + COUNT_W'(1);
        end
      end

      if (load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end

      if (cfg_i.wr_frames) begin
        tot_q     <= tf_new;
        top_q     <= tf_new;
        stk_vld_q <= '0;
        own_vld_q <= '0;
      end
      if (cfg_i.wr_size) begin
        fsz_q <= fs_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_issue) begin
      stk_rd_q <= stk_mem[rd_addr];
    end
    if (push_ok) begin
      stk_mem[top_idx] <= FRAME_W'(cmp_idx_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.scan_step && !iss_done_q) begin
      own_rd_q <= own_mem[sc_q];
    end
    if (ctl_i.frame_move) begin
      own_mem[own_idx] <= pid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      pid_q <= pid_i;
    end
    if (load) begin
      status_q <= ctl_i.single_load ? refuse_q : STATUS_OK;
      fv_q     <= ctl_i.frame_move;
      frame_q  <= ctl_i.frame_move ? pend_frame : '0;
      last_q   <= ctl_i.single_load || (rp_q == top_q);
      ofreed_q <= ctl_i.single_load ? freed_q : '0;
      ofree_q  <= top_q;
      obytes_q <= prod[22:0];
      oproc_q  <= proc_q;
      oin_q    <= in_q;
      oout_q   <= outc_q;
    end
  end

  assign total_frames_o  = tot_q;
  assign frame_size_o    = fsz_q;
  assign out_valid_o     = out_vld_q;
  assign status_o        = status_q;
  assign frame_valid_o   = fv_q;
  assign frame_o         = frame_q;
  assign last_o          = last_q;
  assign frames_freed_o  = ofreed_q;
  assign free_frames_o   = ofree_q;
  assign free_bytes_o    = obytes_q;
  assign process_count_o = oproc_q;
  assign paged_in_o      = oin_q;
  assign paged_out_o     = oout_q;

endmodule

`default_nettype wire

// ===== hw/rtl/paging_frame_allocator_core.sv =====
// Page frame allocator with a free-frame stack and an owner table. An
// allocate transaction (cmd 0) pops num_pages frames, tags each with pid and
// returns one result transaction per granted frame, the last one marked with
// last; a request for more frames than are free returns one refusal result
// with status 1, and a request for zero frames returns one success result
// with frame_valid low. A deallocate transaction (cmd 1) scans all frames in
// ascending order, pushes every frame owned by pid back on the stack and
// returns one summary result with frames_freed. Every result carries the
// free count, free bytes, process count and paged-in/out totals as they
// stand after the whole request. One request is worked on at a time. The
// free-stack memory delivers one frame per cycle through its registered read
// port while the result channel does not stall; a deallocate is paced by the
// owner-table scan, which visits one entry per cycle. The next request is
// accepted while the final result still waits in the output register.
// Writing total_frames refills the stack and clears all owners at once
// through per-entry valid bits, so no clearing pass is needed after reset
// or after a write. Configuration is written through an APB-style port with
// total_frames at address 0 and frame_size at address 4; out-of-range values
// are clamped.
`default_nettype none

module paging_frame_allocator_core #(
  parameter int unsigned FRAMES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request channel.
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         cmd_i,
  input  logic [pfa_pkg::PID_W-1:0]    pid_i,
  input  logic [pfa_pkg::COUNT_W-1:0]  num_pages_i,
  // Result channel.
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         status_o,
  output logic                         frame_valid_o,
  output logic [pfa_pkg::FRAME_W-1:0]  frame_o,
  output logic                         last_o,
  output logic [pfa_pkg::COUNT_W-1:0]  frames_freed_o,
  output logic [pfa_pkg::COUNT_W-1:0]  free_frames_o,
  output logic [22:0]                  free_bytes_o,
  output logic [7:0]                   process_count_o,
  output logic [31:0]                  paged_in_o,
  output logic [31:0]                  paged_out_o,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import pfa_pkg::*;

  pfa_cmd_t           ctl;
  pfa_stat_t          stat;
  pfa_cfg_t           cfg;
  logic               cfg_wr;
  logic [COUNT_W-1:0] total_frames;
  logic [SIZE_W-1:0]  frame_size;

  // The port never waits, so a write lands in its access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    cfg           = '0;
    cfg.wdata     = pwdata;
    cfg.wr_frames = cfg_wr && (paddr[2] == REG_TOTAL_FRAMES);
    cfg.wr_size   = cfg_wr && (paddr[2] == REG_FRAME_SIZE);
  end

  // Reads return the clamped value held in the register.
  always_comb begin
    unique case (paddr[2])
      REG_TOTAL_FRAMES: prdata = 32'(total_frames);
      REG_FRAME_SIZE:   prdata = 32'(frame_size);
      default:          prdata = '0;
    endcase
  end

  pfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  pfa_datapath #(
    .FRAMES (FRAMES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .stat_o          (stat),
    .cfg_i           (cfg),
    .total_frames_o  (total_frames),
    .frame_size_o    (frame_size),
    .cmd_i           (cmd_i),
    .pid_i           (pid_i),
    .num_pages_i     (num_pages_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .frame_valid_o   (frame_valid_o),
    .frame_o         (frame_o),
    .last_o          (last_o),
    .frames_freed_o  (frames_freed_o),
    .free_frames_o   (free_frames_o),
    .free_bytes_o    (free_bytes_o),
    .process_count_o (process_count_o),
    .paged_in_o      (paged_in_o),
    .paged_out_o     (paged_out_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/pfa_checker.sv =====
`default_nettype none

`include "paging_frame_allocator_core_defines.svh"

module pfa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        status_o,
  input logic                        frame_valid_o,
  input logic                        last_o,
  input logic [pfa_pkg::COUNT_W-1:0] frames_freed_o
);
  import pfa_pkg::*;

  // A stalled result stays offered.
  `PFA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  // A granted frame always comes from a successful allocate.
  `PFA_ASSERT_NOW(a_frame_ok, out_valid_o && frame_valid_o, (status_o == STATUS_OK) && (frames_freed_o == '0), "granted frame with refusal or freed count")

  // Results without a frame are single results and close their request.
  `PFA_ASSERT_NOW(a_single_last, out_valid_o && !frame_valid_o, last_o, "frameless result not marked last")

  // While a frame stream is unfinished no new request may be taken.
  `PFA_ASSERT_NOW(a_busy_stream, out_valid_o && !last_o, in_stall_o, "request open during a frame stream")

endmodule

bind paging_frame_allocator_core pfa_checker u_pfa_checker (.*);

`default_nettype wire
